[rtl/core/tbb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tbb_pkg
// Shared types, constants and helpers for the transformed box bounds core.
// ---------------------------------------------------------------------------
package tbb_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int PROD_W    = 2 * COORD_W;
	// three products plus a shifted offset: two guard bits cover the growth
	localparam int SUM_W     = PROD_W + 2;
	localparam int NUM_AXES  = 3;
	localparam int CFG_IDX_W = 3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [SUM_W-1:0]   sum_t;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_TEST   = 1'b1;

	localparam logic [1:0] AXIS_X    = 2'd0;
	localparam logic [1:0] AXIS_Y    = 2'd1;
	localparam logic [1:0] AXIS_Z    = 2'd2;
	localparam logic [1:0] AXIS_NONE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z = 3'd5;

	localparam coord_t COORD_MAX = coord_t'({1'b0, {(COORD_W-1){1'b1}}});
	localparam coord_t COORD_MIN = coord_t'({1'b1, {(COORD_W-1){1'b0}}});

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} pipe_en_t;

	typedef struct packed {
		logic       command;
		logic [1:0] axis;
		coord_t     offset;
		coord_t     point_x;
		coord_t     point_y;
		coord_t     point_z;
	} item_t;

	// offset scaled into the product's fixed-point position
	function automatic sum_t to_base(input coord_t off);
		return sum_t'(off) <<< FRAC_BITS;
	endfunction

	// floor shift back to coordinate scale, then clamp
	function automatic coord_t sat_coord(input sum_t s);
		sum_t sh;
		sh = s >>> FRAC_BITS;
		if (sh > sum_t'(COORD_MAX))
			return COORD_MAX;
		else if (sh < sum_t'(COORD_MIN))
			return COORD_MIN;
		else
			return coord_t'(sh[COORD_W-1:0]);
	endfunction

endpackage
`default_nettype wire

[rtl/core/tbb_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tbb_lane
// One local axis: coefficient times both box bounds, then min/max sort.
// ---------------------------------------------------------------------------
module tbb_lane (
	input  wire logic             clk,
	input  wire tbb_pkg::pipe_en_t en,
	input  wire tbb_pkg::coord_t  coef,
	input  wire tbb_pkg::coord_t  bound_lo,
	input  wire tbb_pkg::coord_t  bound_hi,
	output tbb_pkg::prod_t        min_s2,
	output tbb_pkg::prod_t        max_s2
);
	import tbb_pkg::*;

	prod_t p_s1;
	prod_t q_s1;
	prod_t p_c;
	prod_t q_c;

	assign p_c = prod_t'(coef) * prod_t'(bound_lo);
	assign q_c = prod_t'(coef) * prod_t'(bound_hi);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			p_s1 <= p_c;
			q_s1 <= q_c;
		end
		if (en.s2) begin
			if (p_s1 <= q_s1) begin
				min_s2 <= p_s1;
				max_s2 <= q_s1;
			end else begin
				min_s2 <= q_s1;
				max_s2 <= p_s1;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/tbb_merge.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tbb_merge
// Adds the lane extremes to the offset, floor shifts and saturates.
// ---------------------------------------------------------------------------
module tbb_merge (
	input  wire logic              clk,
	input  wire tbb_pkg::pipe_en_t en,
	input  wire tbb_pkg::coord_t   offset_s2,
	input  wire tbb_pkg::prod_t    mins_s2 [tbb_pkg::NUM_AXES],
	input  wire tbb_pkg::prod_t    maxs_s2 [tbb_pkg::NUM_AXES],
	output tbb_pkg::coord_t        low_sat,
	output tbb_pkg::coord_t        high_sat
);
	import tbb_pkg::*;

	sum_t lo_a_s3;
	sum_t lo_b_s3;
	sum_t hi_a_s3;
	sum_t hi_b_s3;
	sum_t base;

	assign base = to_base(offset_s2);

	// split the four-term sum over two stages
	always_ff @(posedge clk) begin
		if (en.s3) begin
			lo_a_s3 <= base + sum_t'(mins_s2[0]);
			lo_b_s3 <= sum_t'(mins_s2[1]) + sum_t'(mins_s2[2]);
			hi_a_s3 <= base + sum_t'(maxs_s2[0]);
			hi_b_s3 <= sum_t'(maxs_s2[1]) + sum_t'(maxs_s2[2]);
		end
	end

	assign low_sat  = sat_coord(lo_a_s3 + lo_b_s3);
	assign high_sat = sat_coord(hi_a_s3 + hi_b_s3);

endmodule
`default_nettype wire

[rtl/core/transformed_box_bounds_and_hit_test_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// The input transfer registers the multiply, then the item passes through sort,
// add and add+clamp to out_valid. Throughput: one item per cycle; bubbles
// compress, so input stalls only when all four stages are full and output stalls.
// Tests are evaluated in the last stage against the stored ranges, so they see
// every earlier update. Reset clears the local box to zero and empties the world
// ranges (low at the most positive value, high at the most negative).
// ---------------------------------------------------------------------------
// transformed_box_bounds_and_hit_test_core
// World-space bounds of a transformed local box and a point containment test.
// ---------------------------------------------------------------------------
module transformed_box_bounds_and_hit_test_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration
	input  wire logic                              cfg_we,
	input  wire logic [tbb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire tbb_pkg::coord_t                   cfg_data,
	// input channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              command,
	input  wire logic [1:0]                        axis,
	input  wire tbb_pkg::coord_t                   coef_x,
	input  wire tbb_pkg::coord_t                   coef_y,
	input  wire tbb_pkg::coord_t                   coef_z,
	input  wire tbb_pkg::coord_t                   coef_offset,
	input  wire tbb_pkg::coord_t                   point_x,
	input  wire tbb_pkg::coord_t                   point_y,
	input  wire tbb_pkg::coord_t                   point_z,
	// output channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output tbb_pkg::coord_t                        axis_low,
	output tbb_pkg::coord_t                        axis_high,
	output logic                                   hit
);
	import tbb_pkg::*;

	coord_t local_lo_q [NUM_AXES];
	coord_t local_hi_q [NUM_AXES];
	coord_t world_low_q [NUM_AXES];
	coord_t world_high_q [NUM_AXES];
	coord_t coefs [NUM_AXES];

	logic v1_q, v2_q, v3_q, out_valid_q;
	logic rdy1, rdy2, rdy3, rdy4;
	pipe_en_t en;
	item_t item_s1, item_s2, item_s3;
	prod_t mins_s2 [NUM_AXES];
	prod_t maxs_s2 [NUM_AXES];
	coord_t low_sat, high_sat;
	logic hit_c, out_load, world_we;

	coord_t axis_low_q, axis_high_q;
	logic hit_q, out_cmd_q;
	logic [1:0] out_axis_q;

	assign coefs[0] = coef_x;
	assign coefs[1] = coef_y;
	assign coefs[2] = coef_z;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				local_lo_q[i] <= '0;
				local_hi_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_X: local_lo_q[0] <= cfg_data;
				CFG_MIN_Y: local_lo_q[1] <= cfg_data;
				CFG_MIN_Z: local_lo_q[2] <= cfg_data;
				CFG_MAX_X: local_hi_q[0] <= cfg_data;
				CFG_MAX_Y: local_hi_q[1] <= cfg_data;
				CFG_MAX_Z: local_hi_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage flow control: a stage moves when it is empty or its successor moves
	assign rdy4 = !out_valid_q || !out_stall;
	assign rdy3 = !v3_q || rdy4;
	assign rdy2 = !v2_q || rdy3;
	assign rdy1 = !v1_q || rdy2;
	assign in_stall = !rdy1;

	assign en.s1 = in_valid && rdy1;
	assign en.s2 = v1_q && rdy2;
	assign en.s3 = v2_q && rdy3;
	assign out_load = v3_q && rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= in_valid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
			if (rdy4) out_valid_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			item_s1.command <= command;
			item_s1.axis    <= axis;
			item_s1.offset  <= coef_offset;
			item_s1.point_x <= point_x;
			item_s1.point_y <= point_y;
			item_s1.point_z <= point_z;
		end
		if (en.s2) item_s2 <= item_s1;
		if (en.s3) item_s3 <= item_s2;
	end

	for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
		tbb_lane u_lane (
			.clk      (clk),
			.en       (en),
			.coef     (coefs[g]),
			.bound_lo (local_lo_q[g]),
			.bound_hi (local_hi_q[g]),
			.min_s2   (mins_s2[g]),
			.max_s2   (maxs_s2[g])
		);
	end

	tbb_merge u_merge (
		.clk       (clk),
		.en        (en),
		.offset_s2 (item_s2.offset),
		.mins_s2   (mins_s2),
		.maxs_s2   (maxs_s2),
		.low_sat   (low_sat),
		.high_sat  (high_sat)
	);

	// containment against ranges already updated by every earlier item
	assign hit_c = (world_low_q[0] <= item_s3.point_x) && (item_s3.point_x <= world_high_q[0])
		&& (world_low_q[1] <= item_s3.point_y) && (item_s3.point_y <= world_high_q[1])
		&& (world_low_q[2] <= item_s3.point_z) && (item_s3.point_z <= world_high_q[2]);

	assign world_we = out_load && (item_s3.command == CMD_UPDATE)
		&& (item_s3.axis != AXIS_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				world_low_q[i]  <= COORD_MAX;
				world_high_q[i] <= COORD_MIN;
			end
		end else if (world_we) begin
			world_low_q[item_s3.axis]  <= low_sat;
			world_high_q[item_s3.axis] <= high_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_cmd_q  <= item_s3.command;
			out_axis_q <= item_s3.axis;
			if (item_s3.command == CMD_UPDATE) begin
				axis_low_q  <= low_sat;
				axis_high_q <= high_sat;
				hit_q       <= 1'b0;
			end else begin
				axis_low_q  <= '0;
				axis_high_q <= '0;
				hit_q       <= hit_c;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign axis_low  = axis_low_q;
	assign axis_high = axis_high_q;
	assign hit       = hit_q;

	// a stalled input means every stage is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v1_q && v2_q && v3_q && out_valid_q))
		else $error("input stalled with an empty pipeline stage");

	// a shown update result matches what was stored for its axis
	a_update_stored: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_cmd_q == CMD_UPDATE && out_axis_q != AXIS_NONE)
		|-> (world_low_q[out_axis_q] == axis_low && world_high_q[out_axis_q] == axis_high))
		else $error("stored world range differs from returned bounds");

	// updates never report a hit, tests never report bounds
	a_update_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_cmd_q == CMD_UPDATE) |-> !hit)
		else $error("update result carries a hit");

	a_test_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_cmd_q == CMD_TEST) |-> (axis_low == '0 && axis_high == '0))
		else $error("test result carries nonzero bounds");

endmodule
`default_nettype wire
